FILE: design/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

   // Hue segment of the channel curve: rise, flat high, fall, flat low
   typedef logic [1:0] hsl2rgb_seg_type;

   localparam hsl2rgb_seg_type SEG_RISE = 2'd0;
   localparam hsl2rgb_seg_type SEG_HIGH = 2'd1;
   localparam hsl2rgb_seg_type SEG_FALL = 2'd2;
   localparam hsl2rgb_seg_type SEG_LOW  = 2'd3;

   // Pipeline control handed from the top level to each channel lane
   typedef struct packed {
      logic advance;   // all stages move one place this cycle
   } hsl2rgb_ctl_type;

endpackage

FILE: design/hsl2rgb_ifs.sv
// Request channel: one HSL colour per transfer
interface hsl2rgb_req_if #(parameter int FRAC_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS-1:0] hue;
   logic [FRAC_BITS:0]   saturation;
   logic [FRAC_BITS:0]   lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

// Response channel: one 8-bit RGB triple per transfer
interface hsl2rgb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: design/hsl2rgb_channel.sv
// One colour lane: segment select, ramp multiply, scale to 8 bits
module hsl2rgb_channel #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  hsl2rgb_pkg::hsl2rgb_ctl_type ctl,
   input  logic [FRAC_BITS:0]          p_val,
   input  logic [FRAC_BITS:0]          q_val,
   input  logic [FRAC_BITS-1:0]        hue_pos,
   output logic [7:0]                  level
);

   localparam int F     = FRAC_BITS;
   localparam int ONE_I = 1 << FRAC_BITS;

   localparam logic [F:0]   ONE_V        = (F+1)'(ONE_I);
   localparam logic [F-1:0] HALF_V       = F'(ONE_I / 2);
   localparam logic [F-1:0] SIXTH_CEIL   = F'((ONE_I + 5) / 6);
   localparam logic [F-1:0] TWO_3RD_CEIL = F'((2 * ONE_I + 2) / 3);
   localparam logic [F+2:0] FOUR_ONE     = (F+3)'(4 * ONE_I);

   // Stage D: segment, ramp factor and span
   logic [F+2:0]                 t6;
   hsl2rgb_pkg::hsl2rgb_seg_type seg_in;
   logic [F+2:0]                 fac_in;
   logic [F:0]                   span_in;

   hsl2rgb_pkg::hsl2rgb_seg_type seg_d_ff;
   logic [F+2:0]                 fac_d_ff;
   logic [F:0]                   span_d_ff;
   logic [F:0]                   p_d_ff;
   logic [F:0]                   q_d_ff;

   assign t6      = {1'b0, hue_pos, 2'b00} + {2'b00, hue_pos, 1'b0};
   assign span_in = q_val - p_val;

   always_comb begin
      if (hue_pos < SIXTH_CEIL) begin
         seg_in = hsl2rgb_pkg::SEG_RISE;
      end else if (hue_pos < HALF_V) begin
         seg_in = hsl2rgb_pkg::SEG_HIGH;
      end else if (hue_pos < TWO_3RD_CEIL) begin
         seg_in = hsl2rgb_pkg::SEG_FALL;
      end else begin
         seg_in = hsl2rgb_pkg::SEG_LOW;
      end
   end

   // falling edge uses 4 - 6t; only meaningful inside that segment
   assign fac_in = (seg_in == hsl2rgb_pkg::SEG_RISE) ? t6 : (FOUR_ONE - t6);

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         seg_d_ff  <= seg_in;
         fac_d_ff  <= fac_in;
         span_d_ff <= span_in;
         p_d_ff    <= p_val;
         q_d_ff    <= q_val;
      end
   end

   // Stage E: span times ramp factor
   logic [2*F+3:0]               prod_e_ff;
   hsl2rgb_pkg::hsl2rgb_seg_type seg_e_ff;
   logic [F:0]                   p_e_ff;
   logic [F:0]                   q_e_ff;

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         prod_e_ff <= span_d_ff * fac_d_ff;
         seg_e_ff  <= seg_d_ff;
         p_e_ff    <= p_d_ff;
         q_e_ff    <= q_d_ff;
      end
   end

   // Stage F: pick level, clip to one, scale by 255 and truncate
   logic [F+3:0] ramp;
   logic [F+4:0] ramp_sum;
   logic [F+4:0] v_raw;
   logic [F:0]   v_clip;
   logic [F+8:0] scaled;
   logic [7:0]   level_in;
   logic [7:0]   level_ff;

   assign ramp     = prod_e_ff[2*F+3:F];
   assign ramp_sum = {4'b0000, p_e_ff} + {1'b0, ramp};

   always_comb begin
      case (seg_e_ff)
         hsl2rgb_pkg::SEG_RISE: v_raw = ramp_sum;
         hsl2rgb_pkg::SEG_FALL: v_raw = ramp_sum;
         hsl2rgb_pkg::SEG_HIGH: v_raw = {4'b0000, q_e_ff};
         default:               v_raw = {4'b0000, p_e_ff};
      endcase
   end

   assign v_clip   = (v_raw > {4'b0000, ONE_V}) ? ONE_V : v_raw[F:0];
   assign scaled   = {v_clip, 8'h00} - {8'h00, v_clip};
   assign level_in = scaled[F+7:F];

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

FILE: design/hsl_to_rgb_converter.sv
// A request transfer passes through stage registers A to F before its response is offered.
// Throughput: one colour per cycle; the six-stage pipeline takes a new item
// every cycle and only freezes as a whole while a response is held unaccepted.
// Reset (synchronous, active high) clears the stage valid bits and holds off
// the request channel; datapath registers are not reset.
module hsl_to_rgb_converter #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   hsl2rgb_req_if.sink  req_chan,
   hsl2rgb_rsp_if.source rsp_chan
);

   localparam int F     = FRAC_BITS;
   localparam int ONE_I = 1 << FRAC_BITS;
   localparam int NSTG  = 6;

   localparam logic [F:0]   ONE_V    = (F+1)'(ONE_I);
   localparam logic [F:0]   HALF_V   = (F+1)'(ONE_I / 2);
   localparam logic [F-1:0] THIRD_V  = F'(ONE_I / 3);
   localparam logic [F-1:0] BLUE_OFS = F'(ONE_I - ONE_I / 3);

   // Pipeline control: whole pipe moves unless the output is stalled
   logic                         advance;
   logic [NSTG-1:0]              vld_ff;
   hsl2rgb_pkg::hsl2rgb_ctl_type ctl;

   assign advance      = !vld_ff[NSTG-1] || rsp_chan.ready;
   assign req_chan.ready = advance && !reset;
   assign ctl.advance  = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_chan.valid};
      end
   end

   // Stage A: clip inputs, hue offsets, q product
   logic [F:0]   s_clip;
   logic [F:0]   l_clip;
   logic         l_low;
   logic [F+1:0] mul_b;
   logic [F-1:0] hue_r;
   logic [F-1:0] hue_b;

   logic [2*F+2:0]         prod_a_ff;
   logic [F:0]             l_a_ff;
   logic [F:0]             s_a_ff;
   logic                   low_a_ff;
   logic [2:0][F-1:0]      t_a_ff;

   assign s_clip = (req_chan.saturation > ONE_V) ? ONE_V : req_chan.saturation;
   assign l_clip = (req_chan.lightness > ONE_V) ? ONE_V : req_chan.lightness;
   assign l_low  = l_clip < HALF_V;
   assign mul_b  = l_low ? ({1'b0, ONE_V} + {1'b0, s_clip}) : {1'b0, s_clip};
   assign hue_r  = req_chan.hue + THIRD_V;
   assign hue_b  = req_chan.hue + BLUE_OFS;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_a_ff <= l_clip * mul_b;
         l_a_ff    <= l_clip;
         s_a_ff    <= s_clip;
         low_a_ff  <= l_low;
         t_a_ff    <= {hue_b, req_chan.hue, hue_r};
      end
   end

   // Stage B: finish q for both lightness halves, clip to one
   logic [F+2:0] prod_hi;
   logic [F+1:0] lq;
   logic [F+2:0] q_hi;
   logic [F+2:0] q_raw;
   logic [F:0]   q_clip;

   logic [F:0]        q_b_ff;
   logic [F:0]        l_b_ff;
   logic [2:0][F-1:0] t_b_ff;

   assign prod_hi = prod_a_ff[2*F+2:F];
   assign lq      = {1'b0, l_a_ff} + {1'b0, s_a_ff};
   assign q_hi    = ({1'b0, lq} >= prod_hi) ? ({1'b0, lq} - prod_hi) : '0;
   assign q_raw   = low_a_ff ? prod_hi : q_hi;
   assign q_clip  = (q_raw > {2'b00, ONE_V}) ? ONE_V : q_raw[F:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         q_b_ff <= q_clip;
         l_b_ff <= l_a_ff;
         t_b_ff <= t_a_ff;
      end
   end

   // Stage C: p = 2l - q, held to [0, q]
   logic [F+1:0] l2;
   logic [F+1:0] pp;
   logic [F:0]   p_clip;

   logic [F:0]        p_c_ff;
   logic [F:0]        q_c_ff;
   logic [2:0][F-1:0] t_c_ff;

   assign l2     = {l_b_ff, 1'b0};
   assign pp     = (l2 >= {1'b0, q_b_ff}) ? (l2 - {1'b0, q_b_ff}) : '0;
   assign p_clip = (pp > {1'b0, q_b_ff}) ? q_b_ff : pp[F:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         p_c_ff <= p_clip;
         q_c_ff <= q_b_ff;
         t_c_ff <= t_b_ff;
      end
   end

   // Stages D to F: one lane per colour (red, green, blue)
   logic [2:0][7:0] level;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      hsl2rgb_channel #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .ctl     (ctl),
         .p_val   (p_c_ff),
         .q_val   (q_c_ff),
         .hue_pos (t_c_ff[i]),
         .level   (level[i])
      );
   end

   assign rsp_chan.valid = vld_ff[NSTG-1];
   assign rsp_chan.red   = level[0];
   assign rsp_chan.green = level[1];
   assign rsp_chan.blue  = level[2];

endmodule

FILE: sim/hsl_to_rgb_converter_test.sv
module hsl_to_rgb_converter_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS    = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   // Fixed-point constants of the colour curve
   localparam logic [63:0] ONE             = 64'd1 << FRAC_BITS;
   localparam logic [63:0] THIRD           = ONE / 3;
   localparam logic [63:0] SIXTH_CEIL      = (ONE + 5) / 6;
   localparam logic [63:0] HALF            = ONE >> 1;
   localparam logic [63:0] TWO_THIRDS_CEIL = (2 * ONE + 2) / 3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_triple_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hsl2rgb_req_if #(.FRAC_BITS(FRAC_BITS)) req_bus ();
   hsl2rgb_rsp_if                          rsp_bus ();

   hsl_to_rgb_converter #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   rgb_triple_type expected_rgb[$];
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int holds_asked    = 0;
   int holds_granted  = 0;
   int hold_left      = 0;
   int mismatches     = 0;
   int colours_sent   = 0;
   int results_seen   = 0;
   int cycle_count    = 0;

   always #10 clock = ~clock;

   // Channel level from the curve position t, scaled to 0..255
   function automatic logic [7:0] channel_level(input logic [63:0] p, input logic [63:0] q,
                                                input logic [63:0] t);
      hsl2rgb_pkg::hsl2rgb_seg_type seg;
      logic [63:0]     span;
      logic [63:0]     level;
      logic [63:0]     scaled;
      span = q - p;
      if (t < SIXTH_CEIL)           seg = hsl2rgb_pkg::SEG_RISE;
      else if (t < HALF)            seg = hsl2rgb_pkg::SEG_HIGH;
      else if (t < TWO_THIRDS_CEIL) seg = hsl2rgb_pkg::SEG_FALL;
      else                          seg = hsl2rgb_pkg::SEG_LOW;
      case (seg)
         hsl2rgb_pkg::SEG_RISE: level = p + ((span * (6 * t)) >> FRAC_BITS);
         hsl2rgb_pkg::SEG_HIGH: level = q;
         hsl2rgb_pkg::SEG_FALL: level = p + ((span * (4 * ONE - 6 * t)) >> FRAC_BITS);
         default:  level = p;
      endcase
      if (level > ONE) level = ONE;
      scaled = (level * 255) >> FRAC_BITS;
      return scaled[7:0];
   endfunction

   // Expected RGB triple for one HSL colour
   function automatic rgb_triple_type hsl_colour_to_rgb(input logic [15:0] hue,
                                                        input logic [16:0] sat,
                                                        input logic [16:0] light);
      logic [63:0]    h, s, l, q, p, prod;
      rgb_triple_type rgb;
      h = {48'd0, hue};
      s = (sat > ONE) ? ONE : {47'd0, sat};
      l = (light > ONE) ? ONE : {47'd0, light};
      if (l < HALF) begin
         q = (l * (ONE + s)) >> FRAC_BITS;
      end else begin
         prod = (l * s) >> FRAC_BITS;
         q = (l + s >= prod) ? (l + s - prod) : 64'd0;
      end
      if (q > ONE) q = ONE;
      // p = 2l - q, held to [0, q]
      p = (2 * l > q) ? (2 * l - q) : 64'd0;
      if (p > q) p = q;
      rgb.red   = channel_level(p, q, (h + THIRD) & (ONE - 1));
      rgb.green = channel_level(p, q, h);
      rgb.blue  = channel_level(p, q, (h + (ONE - THIRD)) & (ONE - 1));
      return rgb;
   endfunction

   // Saturation or lightness: mostly in range, with the ends and overrange values
   function automatic logic [16:0] pick_level();
      case ($urandom_range(0, 9))
         0:       return 17'($urandom_range(0, 131071));
         1:       return 17'(ONE);
         2:       return 17'd0;
         3:       return 17'($urandom_range(HALF - 4, HALF + 4));
         default: return 17'($urandom_range(0, ONE));
      endcase
   endfunction

   // Offer one colour and wait for its transfer
   task automatic send_colour(input logic [15:0] hue, input logic [16:0] sat,
                              input logic [16:0] light);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.hue        <= hue;
      req_bus.saturation <= sat;
      req_bus.lightness  <= light;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_rgb.push_back(hsl_colour_to_rgb(hue, sat, light));
      colours_sent++;
   endtask

   task automatic send_random_colour();
      logic [15:0] hue;
      if ($urandom_range(0, 7) == 0)
         hue = 16'($urandom_range(0, 5) * (ONE / 6) + $urandom_range(0, 4) - 2);
      else
         hue = 16'($urandom_range(0, 65535));
      send_colour(hue, pick_level(), pick_level());
   endtask

   // Stop offering and wait until every transfer has come back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_rgb.size() != 0) @(posedge clock);
   endtask

   // Ends of the saturation and lightness ranges, including values above 1.0
   task automatic test_field_extremes();
      send_colour(16'd0,     17'd0,      17'd0);
      send_colour(16'hffff,  17'd65536,  17'd65536);
      send_colour(16'd0,     17'd131071, 17'd131071);
      send_colour(16'd21845, 17'd0,      17'd65536);
      send_colour(16'd43690, 17'd65536,  17'd0);
      send_colour(16'd5000,  17'd65536,  17'd32767);
      send_colour(16'd5000,  17'd65536,  17'd32768);
      send_colour(16'd60000, 17'd32768,  17'd65536);
      send_colour(16'hffff,  17'd65537,  17'd40000);
      send_colour(16'd12345, 17'd30000,  17'd65537);
      send_colour(16'h8000,  17'h1ffff,  17'h10000);
      wait_for_results();
   endtask

   // Hue either side of every segment boundary of the curve
   task automatic test_segment_edges();
      send_colour(16'd10922, 17'd65536, 17'd32768);
      send_colour(16'd10923, 17'd65536, 17'd32768);
      send_colour(16'd32767, 17'd65536, 17'd32768);
      send_colour(16'd32768, 17'd65536, 17'd32768);
      send_colour(16'd43690, 17'd65536, 17'd32768);
      send_colour(16'd43691, 17'd65536, 17'd32768);
      send_colour(16'd10922, 17'd40000, 17'd20000);
      send_colour(16'd43690, 17'd40000, 17'd50000);
      send_colour(16'd0,     17'd52000, 17'd31000);
      send_colour(16'hffff,  17'd52000, 17'd31000);
      wait_for_results();
   endtask

   task automatic test_random_phase(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_random_colour();
      wait_for_results();
   endtask

   // Long receiver hold-off with the sender still pushing, then a full pause
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holds_asked++;
      repeat (40) send_random_colour();
      wait_for_results();
      repeat (10) send_random_colour();
      wait_for_results();
   endtask

   // Receiver: checks each result transfer and drives ready
   always @(posedge clock) begin
      rgb_triple_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (expected_rgb.size() == 0) begin
            $error("result red=%0d green=%0d blue=%0d with none expected",
                   rsp_bus.red, rsp_bus.green, rsp_bus.blue);
            mismatches++;
         end else begin
            want = expected_rgb.pop_front();
            if (rsp_bus.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_bus.red);
               mismatches++;
            end
            if (rsp_bus.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_bus.green);
               mismatches++;
            end
            if (rsp_bus.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_bus.blue);
               mismatches++;
            end
         end
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (holds_granted != holds_asked) begin
         rsp_bus.ready <= 1'b0;
         hold_left = HOLD_CYCLES;
         holds_granted++;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_rgb.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.hue        <= '0;
      req_bus.saturation <= '0;
      req_bus.lightness  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_segment_edges();
      test_random_phase(180, 10, 57);
      test_random_phase(180, 57, 10);
      test_backpressure();
      test_random_phase(150, 0, 0);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d colours sent, %0d results checked in %0d cycles", colours_sent,
               results_seen, cycle_count);
      $display("covered range ends, overrange levels, hue segment edges, random stalls");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
